/* rtl/dspm_pkg.sv */
// shared constants and types for the divisor sum of power modulo prime core
// no dependencies
package dspm_pkg;
   localparam int ValueWidth = 26;
   localparam int ModWidth   = 16;
   localparam int TrialLimit = 8192;
   localparam int TrialWidth = 14;
   localparam int ExpWidth   = 32;
   localparam int CountWidth = $clog2(ValueWidth + 1);
   localparam int ReqWidth   = ((2 * ValueWidth + 7) / 8) * 8;
   localparam int RspWidth   = ((ModWidth + 7) / 8) * 8;
   localparam logic [ModWidth-1:0] ModulusReset = 16'd9901;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV
   } op_type;

   typedef struct packed {
      logic                  start;
      op_type                op;
      logic [ExpWidth-1:0]   num;
      logic [ExpWidth-1:0]   mul_b;
      logic [ExpWidth-1:0]   den;
   } arith_req_type;
endpackage

/* rtl/dspm_arith.sv */
// bit-serial arithmetic unit: shift-add multiply or restoring divide, one bit per cycle
// depends on dspm_pkg
module dspm_arith (
   input  logic                              clock,
   input  logic                              reset,
   input  dspm_pkg::arith_req_type           req,
   output logic                              done,
   output logic [2*dspm_pkg::ExpWidth-1:0]   prod,
   output logic [dspm_pkg::ExpWidth-1:0]     quot,
   output logic [dspm_pkg::ExpWidth-1:0]     rem
);
   localparam int W = dspm_pkg::ExpWidth;

   logic                 busy_ff;
   dspm_pkg::op_type     op_ff;
   logic [5:0]           cnt_ff;
   logic [2*W-1:0]       acc_ff;
   logic [W-1:0]         a_ff;
   logic [W-1:0]         b_ff;
   logic [W-1:0]         rem_ff;
   logic                 done_ff;
   logic [W:0]           trial;
   logic [W-1:0]         rem_sh;

   assign rem_sh = {rem_ff[W-2:0], a_ff[W-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            op_ff   <= req.op;
            cnt_ff  <= 6'(W);
            a_ff    <= req.num;
            b_ff    <= (req.op == dspm_pkg::OP_MUL) ? req.mul_b : req.den;
            acc_ff  <= '0;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            case (op_ff)
               dspm_pkg::OP_MUL: begin
                  acc_ff <= (acc_ff << 1) + (a_ff[W-1] ? {{W{1'b0}}, b_ff} : '0);
                  a_ff   <= a_ff << 1;
               end
               default: begin
                  if (!trial[W]) begin
                     rem_ff <= trial[W-1:0];
                     a_ff   <= {a_ff[W-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     a_ff   <= {a_ff[W-2:0], 1'b0};
                  end
               end
            endcase
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
   assign quot = a_ff;
   assign rem  = rem_ff;

   ap_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start) else $error("start while busy");
   ap_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   ap_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 6'd0) |-> busy_ff) else $error("count without busy");
endmodule

/* rtl/divisor_sum_of_power_mod_prime_core.sv */
// top level: sum of divisors of a^b modulo a prime, digit-serial datapath, depends on
// dspm_pkg and dspm_arith; one 32-bit divide per trial candidate, up to 8191 candidates;
// per prime a divide for v mod m and a multiply for e*b, then two modular powers (31 bits
// for v^(p+1), 16 for the inverse; a fold of p+1 mod m when v mod m is 1), then a multiply
// and reduce into the running product; throughput: one word at a time, the next is accepted
// once the result word has left; synchronous reset restores modulus 9901 and idles the core
module divisor_sum_of_power_mod_prime_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dspm_pkg::ReqWidth-1:0] req_tdata,   // base_value[25:0], power[51:26]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dspm_pkg::RspWidth-1:0] rsp_tdata,   // divisor_sum[15:0]
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [15:0]                   csr_data
);
   localparam int W  = dspm_pkg::ExpWidth;
   localparam int PW = 2 * dspm_pkg::ExpWidth;
   localparam int MW = dspm_pkg::ModWidth;
   localparam int VW = dspm_pkg::ValueWidth;
   localparam int CW = dspm_pkg::CountWidth;
   localparam int TW = dspm_pkg::TrialWidth + 1;
   localparam int RW = dspm_pkg::RspWidth;
   localparam logic [5:0] FoldSteps   = 6'd32;
   localparam logic [5:0] StepProdDiv = 6'd61;
   localparam logic [5:0] StepProdMul = 6'd62;
   localparam logic [5:0] StepFactor  = 6'd63;

   typedef enum logic [4:0] {
      S_IDLE, S_TDIV, S_TDIV_W, S_DDIV, S_DDIV_W, S_PRIME, S_P1, S_P1_W,
      S_PW_STEP, S_PW_MUL_W, S_PW_MOD_W, S_PW_SQ_W, S_PW_SQM_W, S_PW_END,
      S_FMUL_W, S_FMOD_W, S_OUT, S_VMOD_W
   } state_type;

   typedef enum logic [1:0] { PH_NUM, PH_DEN, PH_FOLD } phase_type;

   state_type            state_ff;
   phase_type            phase_ff;
   logic [MW-1:0]        modulus_ff;
   logic [VW-1:0]        remaining_ff;
   logic [VW-1:0]        power_ff;
   logic [TW-1:0]        trial_ff;
   logic [CW-1:0]        count_ff;
   logic [MW-1:0]        product_ff;
   logic [MW-1:0]        pbase_ff;
   logic [MW-1:0]        pacc_ff;
   logic [W:0]           exp_ff;
   logic [VW-1:0]        prime_ff;
   logic [MW-1:0]        vmod_ff;
   logic [MW-1:0]        num_ff;
   logic                 last_ff;
   logic                 rsp_valid_ff;
   logic [MW-1:0]        rsp_data_ff;
   logic [5:0]           p1_step_ff;
   logic [PW-1:0]        p1_ff;

   dspm_pkg::arith_req_type arith_req_ff;
   dspm_pkg::arith_req_type arith_req_in;
   logic                 ar_done;
   logic [PW-1:0]        ar_prod;
   logic [W-1:0]         ar_quot;
   logic [W-1:0]         ar_rem;

   dspm_arith u_arith (
      .clock(clock), .reset(reset), .req(arith_req_ff), .done(ar_done),
      .prod(ar_prod), .quot(ar_quot), .rem(ar_rem)
   );

   logic [MW-1:0] m1;
   logic [W-1:0]  p1_low;
   logic [MW-1:0] num_val;
   logic [MW-1:0] den_base;
   logic          tdiv_end;
   assign m1 = modulus_ff - MW'(1);
   assign p1_low = p1_ff[W-1:0];
   assign num_val = (pacc_ff == '0) ? m1 : pacc_ff - MW'(1);
   assign den_base = (vmod_ff == '0) ? m1 : vmod_ff - MW'(1);
   assign tdiv_end = (trial_ff > TW'(dspm_pkg::TrialLimit)) || (remaining_ff <= VW'(1));

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RW'(rsp_data_ff);

   // one-cycle request pulse to the arithmetic unit
   always_comb begin
      arith_req_in = '0;
      case (state_ff)
         S_TDIV: begin
            if (!tdiv_end)
               arith_req_in = '{1'b1, dspm_pkg::OP_DIV, W'(remaining_ff), '0, W'(trial_ff)};
         end
         S_DDIV: begin
            arith_req_in = '{1'b1, dspm_pkg::OP_DIV, W'(remaining_ff), '0, W'(trial_ff)};
         end
         S_PRIME: begin
            arith_req_in = '{1'b1, dspm_pkg::OP_DIV, W'(prime_ff), '0, W'(modulus_ff)};
         end
         S_VMOD_W: begin
            if (ar_done)
               arith_req_in = '{1'b1, dspm_pkg::OP_MUL, W'(count_ff), W'(power_ff), '0};
         end
         S_PW_STEP: begin
            if (exp_ff != '0) begin
               if (exp_ff[0])
                  arith_req_in = '{1'b1, dspm_pkg::OP_MUL, W'(pacc_ff), W'(pbase_ff), '0};
               else
                  arith_req_in = '{1'b1, dspm_pkg::OP_MUL, W'(pbase_ff), W'(pbase_ff), '0};
            end
         end
         S_PW_MUL_W, S_PW_SQ_W, S_FMUL_W: begin
            if (ar_done)
               arith_req_in = '{1'b1, dspm_pkg::OP_DIV, ar_prod[W-1:0], '0, W'(modulus_ff)};
         end
         S_PW_MOD_W: begin
            if (ar_done && phase_ff != PH_FOLD)
               arith_req_in = '{1'b1, dspm_pkg::OP_MUL, W'(pbase_ff), W'(pbase_ff), '0};
         end
         S_PW_END: begin
            case (phase_ff)
               PH_DEN: begin
                  arith_req_in = '{1'b1, dspm_pkg::OP_MUL, W'(num_ff), W'(pacc_ff), '0};
               end
               PH_FOLD: begin
                  if (p1_step_ff == FoldSteps)
                     arith_req_in = '{1'b1, dspm_pkg::OP_MUL, W'(product_ff), W'(pacc_ff), '0};
                  else
                     arith_req_in = '{1'b1, dspm_pkg::OP_DIV,
                                      W'({pacc_ff, 2'b00}) + W'(p1_ff[PW-1:PW-2]), '0,
                                      W'(modulus_ff)};
               end
               default: arith_req_in = '0;
            endcase
         end
         S_FMOD_W: begin
            if (ar_done) begin
               if (p1_step_ff == StepFactor)
                  arith_req_in = '{1'b1, dspm_pkg::OP_MUL, W'(product_ff), W'(ar_rem), '0};
               else if (p1_step_ff == StepProdMul || p1_step_ff == FoldSteps)
                  arith_req_in = '{1'b1, dspm_pkg::OP_DIV, ar_prod[W-1:0], '0,
                                   W'(modulus_ff)};
            end
         end
         default: arith_req_in = '0;
      endcase
   end

   // p+1 = e*b+1 fits the low word; reduce mod m by shifting in 2 bits per pass
   // with a 16-bit residue: r = (r*4 + digit) mod m using the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         modulus_ff   <= dspm_pkg::ModulusReset;
         rsp_valid_ff <= 1'b0;
         arith_req_ff <= '0;
      end else begin
         arith_req_ff <= arith_req_in;
         if (csr_valid && csr_ready) modulus_ff <= csr_data;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  remaining_ff <= req_tdata[VW-1:0];
                  power_ff     <= req_tdata[2*VW-1:VW];
                  trial_ff     <= TW'(2);
                  if (modulus_ff < MW'(2) || req_tdata[VW-1:0] == '0) begin
                     product_ff <= '0;
                     state_ff   <= S_OUT;
                  end else begin
                     product_ff <= MW'(1);
                     state_ff   <= S_TDIV;
                  end
               end
            end
            S_TDIV: begin
               if (tdiv_end) begin
                  if (remaining_ff > VW'(1)) begin
                     prime_ff <= remaining_ff;
                     count_ff <= CW'(1);
                     last_ff  <= 1'b1;
                     state_ff <= S_PRIME;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end else begin
                  state_ff <= S_TDIV_W;
               end
            end
            S_TDIV_W: if (ar_done) begin
               if (ar_rem == '0) begin
                  remaining_ff <= ar_quot[VW-1:0];
                  prime_ff     <= VW'(trial_ff);
                  count_ff     <= CW'(1);
                  last_ff      <= 1'b0;
                  state_ff     <= S_DDIV;
               end else begin
                  trial_ff <= trial_ff + TW'(1);
                  state_ff <= S_TDIV;
               end
            end
            S_DDIV: begin
               state_ff <= S_DDIV_W;
            end
            S_DDIV_W: if (ar_done) begin
               if (ar_rem == '0) begin
                  remaining_ff <= ar_quot[VW-1:0];
                  count_ff     <= count_ff + CW'(1);
                  state_ff     <= S_DDIV;
               end else begin
                  state_ff <= S_PRIME;
               end
            end
            S_PRIME: begin
               state_ff <= S_VMOD_W;
            end
            S_VMOD_W: if (ar_done) begin
               vmod_ff  <= ar_rem[MW-1:0];
               state_ff <= S_P1;
            end
            S_P1: if (ar_done) begin
               p1_ff <= ar_prod + PW'(1);
               exp_ff <= {1'b0, ar_prod[W-1:0] + W'(1)};
               p1_step_ff <= 6'd0;
               state_ff <= S_P1_W;
            end
            S_P1_W: begin
               // high word is zero for in-range fields; keep 33 bits
               exp_ff <= (p1_ff[PW-1:W] != '0) ? {1'b1, p1_low} : {1'b0, p1_low};
               if (vmod_ff == MW'(1)) begin
                  // p1 mod m: fold digit by digit
                  pacc_ff <= '0;
                  p1_step_ff <= 6'd0;
                  phase_ff <= PH_FOLD;
                  state_ff <= S_PW_END;
               end else begin
                  pacc_ff  <= MW'(1);
                  pbase_ff <= vmod_ff;
                  phase_ff <= PH_NUM;
                  state_ff <= S_PW_STEP;
               end
            end
            S_PW_STEP: begin
               if (exp_ff == '0) begin
                  state_ff <= S_PW_END;
               end else if (exp_ff[0]) begin
                  state_ff <= S_PW_MUL_W;
               end else begin
                  state_ff <= S_PW_SQ_W;
               end
            end
            S_PW_MUL_W: if (ar_done) begin
               state_ff <= S_PW_MOD_W;
            end
            S_PW_MOD_W: if (ar_done) begin
               // the fold loop shares this state and returns to its own step
               pacc_ff  <= ar_rem[MW-1:0];
               state_ff <= (phase_ff == PH_FOLD) ? S_PW_END : S_PW_SQ_W;
            end
            S_PW_SQ_W: if (ar_done) begin
               state_ff <= S_PW_SQM_W;
            end
            S_PW_SQM_W: if (ar_done) begin
               pbase_ff <= ar_rem[MW-1:0];
               exp_ff   <= exp_ff >> 1;
               state_ff <= S_PW_STEP;
            end
            S_PW_END: begin
               case (phase_ff)
                  PH_NUM: begin
                     num_ff   <= num_val;
                     pacc_ff  <= MW'(1);
                     pbase_ff <= den_base;
                     exp_ff   <= {1'b0, W'(modulus_ff - MW'(2))};
                     phase_ff <= PH_DEN;
                     state_ff <= S_PW_STEP;
                  end
                  PH_DEN: begin
                     state_ff <= S_FMUL_W;
                  end
                  default: begin
                     // residue = (residue*4 + next 2 bits of p1) mod m, msb first
                     if (p1_step_ff == FoldSteps) begin
                        state_ff <= S_FMOD_W;
                     end else begin
                        p1_ff <= p1_ff << 2;
                        p1_step_ff <= p1_step_ff + 6'd1;
                        state_ff <= S_PW_MOD_W;
                        phase_ff <= PH_FOLD;
                     end
                  end
               endcase
            end
            S_FMUL_W: if (ar_done) begin
               phase_ff <= PH_FOLD;
               p1_step_ff <= StepFactor;
               state_ff <= S_FMOD_W;
            end
            S_FMOD_W: if (ar_done) begin
               if (p1_step_ff == StepFactor) begin
                  // factor ready, now multiply into running product
                  p1_step_ff <= StepProdMul;
               end else if (p1_step_ff == StepProdMul || p1_step_ff == FoldSteps) begin
                  p1_step_ff <= StepProdDiv;
               end else begin
                  product_ff <= ar_rem[MW-1:0];
                  state_ff   <= last_ff ? S_OUT : S_TDIV;
                  if (!last_ff) trial_ff <= trial_ff + TW'(1);
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= product_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result dropped");
   ap_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   ap_product_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && modulus_ff >= MW'(2) |-> rsp_data_ff < modulus_ff)
      else $error("range");
endmodule

/* bench/testbench.sv */
// self-checking bench for divisor_sum_of_power_mod_prime_core: directed table, then random words
// under several modulus settings, checked against a behavioral divisor-sum predictor
// depends on dspm_pkg and the core rtl
`timescale 1ns / 1ps
module testbench;

   typedef struct {
      logic [dspm_pkg::ValueWidth-1:0] base;
      logic [dspm_pkg::ValueWidth-1:0] pwr;
      bit                              typed;
      logic [dspm_pkg::ModWidth-1:0]   sum;
   } stim_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [dspm_pkg::ReqWidth-1:0] req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [dspm_pkg::RspWidth-1:0] rsp_tdata;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [15:0]                   csr_data;

   logic [dspm_pkg::ModWidth-1:0] modulus_now;
   logic [dspm_pkg::ModWidth-1:0] pending_sums[$];
   int                            mismatches;
   bit                            calm;
   stim_row_type                  table_rows[15];

   divisor_sum_of_power_mod_prime_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned power_mod(longint unsigned x, longint unsigned e,
                                                 longint unsigned m);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % m;
      sq  = x % m;
      while (e != 0) begin
         if (e[0]) acc = (acc * sq) % m;
         sq = (sq * sq) % m;
         e  = e >> 1;
      end
      return acc;
   endfunction

   function automatic longint unsigned prime_term(longint unsigned v, longint unsigned e,
                                                  longint unsigned b, longint unsigned m);
      longint unsigned p1;
      longint unsigned num;
      longint unsigned den;
      p1 = e * b + 1;
      if (v % m == 1) return p1 % m;
      num = (power_mod(v, p1, m) + m - 1) % m;
      den = power_mod((v % m + m - 1) % m, m - 2, m);
      return (num * den) % m;
   endfunction

   function automatic logic [dspm_pkg::ModWidth-1:0] divisor_sum_of(
         logic [dspm_pkg::ValueWidth-1:0] a_in,
         logic [dspm_pkg::ValueWidth-1:0] b_in,
         logic [dspm_pkg::ModWidth-1:0] m_in);
      longint unsigned rest;
      longint unsigned m;
      longint unsigned prod;
      longint unsigned cnt;
      m = m_in;
      if (m < 2 || a_in == 0) return '0;
      rest = a_in;
      prod = 1 % m;
      for (longint unsigned d = 2; d <= dspm_pkg::TrialLimit && rest > 1; d++) begin
         if (rest % d == 0) begin
            cnt = 0;
            while (rest % d == 0) begin
               rest = rest / d;
               cnt++;
            end
            prod = (prod * prime_term(d, cnt, b_in, m)) % m;
         end
      end
      if (rest > 1) prod = (prod * prime_term(rest, 1, b_in, m)) % m;
      return prod[dspm_pkg::ModWidth-1:0];
   endfunction

   task automatic send_word(logic [dspm_pkg::ValueWidth-1:0] a,
                            logic [dspm_pkg::ValueWidth-1:0] b, bit typed,
                            logic [dspm_pkg::ModWidth-1:0] sum);
      logic [dspm_pkg::ModWidth-1:0] want;
      logic [dspm_pkg::ReqWidth-1:0] word;
      want = typed ? sum : divisor_sum_of(a, b, modulus_now);
      word = '0;
      word[2*dspm_pkg::ValueWidth-1:0] = {b, a};
      if (!calm && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      pending_sums = {pending_sums, want};
   endtask

   task automatic drain_and_set(logic [15:0] value);
      req_tvalid <= 1'b0;
      wait (pending_sums.size() == 0);
      repeat (100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      modulus_now = value;
   endtask

   task automatic random_words(int count);
      logic [dspm_pkg::ValueWidth-1:0] a;
      logic [dspm_pkg::ValueWidth-1:0] b;
      logic [31:0]                     rnd;
      for (int i = 0; i < count; i++) begin
         // most bases are small parts shifted up, so trial division ends early
         rnd = $urandom;
         case ($urandom_range(15))
            0:       a = rnd[dspm_pkg::ValueWidth-1:0];
            1:       a = '0;
            default: begin
               rnd = $urandom_range(1, 63) << $urandom_range(0, 25);
               a   = rnd[dspm_pkg::ValueWidth-1:0];
            end
         endcase
         rnd = ($urandom_range(3) == 0) ? $urandom_range(0, 5) : $urandom;
         b   = rnd[dspm_pkg::ValueWidth-1:0];
         send_word(a, b, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: divisor_sum %0d", rsp_tdata);
         end else begin
            logic [dspm_pkg::ModWidth-1:0] want;
            want = pending_sums.pop_front();
            if (rsp_tdata !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("divisor_sum mismatch: expected %0d, got %0d", want, rsp_tdata);
            end
         end
      end
   end

   initial begin
      rsp_tready = 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #(64'd2_000_000_000);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [15:0] phase_mods[8];
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      mismatches  = 0;
      calm        = 1'b0;
      modulus_now = dspm_pkg::ModulusReset;
      phase_mods  = '{16'd3, 16'd65521, 16'd0, 16'd1, 16'd10, 16'd65535, 16'd9973, 16'd2};

      // zero base, base one, zero power, prime equal to modulus, extremes, big cofactor
      table_rows = '{
         '{26'd0,        26'd5,        1'b1, 16'd0},
         '{26'd0,        26'h3FFFFFF,  1'b1, 16'd0},
         '{26'd1,        26'd7,        1'b1, 16'd1},
         '{26'd12,       26'd0,        1'b1, 16'd1},
         '{26'h3FFFFFF,  26'd0,        1'b1, 16'd1},
         '{26'd6,        26'd1,        1'b1, 16'd12},
         '{26'd2,        26'd3,        1'b1, 16'd15},
         '{26'd9901,     26'd1,        1'b1, 16'd1},
         '{26'd9902,     26'd3,        1'b0, 16'd0},
         '{26'd19802,    26'h3FFFFFF,  1'b0, 16'd0},
         '{26'd24627,    26'd2,        1'b0, 16'd0},
         '{26'd2,        26'h3FFFFFF,  1'b0, 16'd0},
         '{26'h2000000,  26'h2AAAAAA,  1'b0, 16'd0},
         '{26'h3FFFFFF,  26'h3FFFFFF,  1'b0, 16'd0},
         '{26'd8191,     26'h1555555,  1'b0, 16'd0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i])
         send_word(table_rows[i].base, table_rows[i].pwr, table_rows[i].typed, table_rows[i].sum);

      foreach (phase_mods[i]) begin
         drain_and_set(phase_mods[i]);
         random_words(8);
      end

      drain_and_set(16'd9901);
      calm = 1'b1;
      random_words(24);
      req_tvalid <= 1'b0;

      wait (pending_sums.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

/* sim.f */
rtl/dspm_pkg.sv
rtl/dspm_arith.sv
rtl/divisor_sum_of_power_mod_prime_core.sv
bench/testbench.sv
